@@ sv/ksc_pkg.sv @@
// ============================================================================
// ksc_pkg
// Shared types and constants for the keypad scan and trigger control block.
// ============================================================================
package ksc_pkg;

    // Key map geometry, fixed by the widths of the level and map words.
    localparam int SINGLE_KEYS = 4;
    localparam int MATRIX_ROWS = 5;
    localparam int MATRIX_COLS = 4;
    localparam int MATRIX_KEYS = MATRIX_ROWS * MATRIX_COLS;
    localparam int MAP_W       = SINGLE_KEYS + MATRIX_KEYS;

    // Map positions of the mode combination and of the scan keys.
    localparam int COMBO_A_BIT   = 3;
    localparam int COMBO_B_BIT   = 5;
    localparam int SCAN_KEY_LO   = 1;
    localparam int SCAN_KEY_HI   = 3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_POL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_CLEAR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_PULSE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_OFF     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_TIMEOUT = 3'd5;
    localparam int CFG_DATA_W = 31;

    // Reset values of the configuration registers.
    localparam logic [3:0]  RST_SINGLE_POL   = 4'd1;
    localparam logic        RST_MATRIX_LEVEL = 1'b0;
    localparam logic        RST_HOLD_CLEAR   = 1'b0;
    localparam logic [9:0]  RST_MANUAL_PULSE = 10'd300;
    localparam logic [9:0]  RST_AUTO_OFF     = 10'd50;
    localparam logic [30:0] RST_AUTO_TIMEOUT = 31'd12000;

    typedef enum logic [1:0] {
        AUTO_OFF   = 2'd0,
        AUTO_RUN   = 2'd1,
        AUTO_ENTER = 2'd2,
        AUTO_LEAVE = 2'd3
    } auto_mode_t;

    typedef struct packed {
        logic [3:0]  single_pol;
        logic        matrix_level;
        logic        hold_clear;
        logic [9:0]  manual_pulse;
        logic [9:0]  auto_off;
        logic [30:0] auto_timeout;
    } cfg_t;

    typedef struct packed {
        auto_mode_t         auto_state;
        logic               aim_active;
        logic signed [10:0] countdown;
        logic [31:0]        last_read;
        logic               trigger;
    } ctl_state_t;

endpackage

@@ sv/ksc_step.sv @@
// ============================================================================
// ksc_step
// Combinational step: builds the key map and the next trigger control state.
// ============================================================================
module ksc_step
    import ksc_pkg::*;
(
    input  cfg_t                     cfg,
    input  ctl_state_t               cur,
    input  logic                     action,
    input  logic [3:0]               single_key_levels,
    input  logic [19:0]              matrix_levels,
    input  logic                     scan_allowed,
    input  logic [31:0]              now_time,
    output ctl_state_t               nxt,
    output logic [MAP_W-1:0]         key_status
);

    always_comb begin
        logic [MAP_W-1:0]       map;
        logic [SINGLE_KEYS-1:0] singles;
        logic [MATRIX_KEYS-1:0] mat;
        logic [31:0]            elapsed;
        logic                   scan_key;
        logic                   was_entering;
        logic signed [10:0]     off_s;

        nxt     = cur;
        singles = ~(single_key_levels ^ cfg.single_pol);
        mat     = cfg.matrix_level ? matrix_levels : ~matrix_levels;
        map     = '0;
        elapsed = now_time - cur.last_read;
        off_s   = $signed({1'b0, cfg.auto_off});
        scan_key     = 1'b0;
        was_entering = 1'b0;

        if (action) begin
            // Successful read reported by the decoder.
            if (cur.auto_state == AUTO_RUN) begin
                nxt.trigger   = 1'b0;
                nxt.countdown = off_s;
                nxt.last_read = now_time;
            end else if (cfg.hold_clear) begin
                nxt.trigger   = 1'b0;
                nxt.countdown = -11'sd1;
            end
        end else begin
            map = {mat, singles};

            // The mode combination toggles auto-scan; its second key is hidden.
            if (map[COMBO_A_BIT] && map[COMBO_B_BIT]) begin
                if (nxt.auto_state == AUTO_OFF) begin
                    nxt.aim_active = 1'b0;
                    nxt.auto_state = AUTO_ENTER;
                    nxt.countdown  = '0;
                    nxt.trigger    = 1'b1;
                end else if (nxt.auto_state == AUTO_RUN) begin
                    nxt.auto_state = AUTO_LEAVE;
                end
                map[COMBO_B_BIT] = 1'b0;
            end

            if (nxt.auto_state == AUTO_RUN && elapsed >= {1'b0, cfg.auto_timeout}) begin
                nxt.auto_state = AUTO_LEAVE;
            end

            if (scan_allowed) begin
                scan_key     = |map[SCAN_KEY_HI:SCAN_KEY_LO];
                was_entering = (nxt.auto_state == AUTO_ENTER);

                if (nxt.auto_state == AUTO_OFF) begin
                    if (!nxt.aim_active && scan_key) begin
                        nxt.trigger    = 1'b1;
                        nxt.countdown  = (nxt.countdown == 11'sd0)
                                         ? $signed({1'b0, cfg.manual_pulse})
                                         : nxt.countdown - 11'sd1;
                        nxt.aim_active = 1'b1;
                    end else if (nxt.aim_active && !scan_key &&
                                 (!cfg.hold_clear || nxt.countdown == -11'sd1)) begin
                        nxt.trigger    = 1'b0;
                        nxt.aim_active = 1'b0;
                        nxt.countdown  = '0;
                    end else begin
                        if (nxt.countdown > 11'sd0) begin
                            nxt.countdown = nxt.countdown - 11'sd1;
                        end
                        if (nxt.aim_active && nxt.countdown == 11'sd0) begin
                            nxt.trigger    = 1'b0;
                            nxt.aim_active = 1'b0;
                        end
                    end
                end else if (nxt.auto_state == AUTO_ENTER && !scan_key) begin
                    nxt.auto_state = AUTO_RUN;
                end else if (nxt.auto_state == AUTO_LEAVE && !scan_key) begin
                    nxt.auto_state = AUTO_OFF;
                    nxt.trigger    = 1'b0;
                    nxt.aim_active = 1'b0;
                    nxt.countdown  = '0;
                end else if (nxt.auto_state == AUTO_RUN) begin
                    if (nxt.countdown == 11'sd0) begin
                        nxt.countdown  = $signed({1'b0, cfg.manual_pulse});
                        nxt.aim_active = 1'b0;
                    end else begin
                        if (nxt.countdown > 11'sd0) begin
                            nxt.countdown = nxt.countdown - 11'sd1;
                        end
                        if (!nxt.aim_active && nxt.countdown >= off_s) begin
                            nxt.trigger    = 1'b1;
                            nxt.aim_active = 1'b1;
                        end else if (nxt.aim_active && nxt.countdown < off_s) begin
                            nxt.trigger    = 1'b0;
                            nxt.aim_active = 1'b0;
                        end
                    end
                end

                // Entering auto-scan starts the idle timer.
                if (was_entering && nxt.auto_state == AUTO_RUN) begin
                    nxt.last_read = now_time;
                end
            end
        end

        key_status = map;
    end

endmodule

@@ sv/keypad_scan_trigger_control_top.sv @@
// ============================================================================
// keypad_scan_trigger_control_top
// Path: an accepted word is held in the input register, then in the result register.
// Throughput: one word per cycle unless m_ready stalls; the state updates in one step.
// Reset: synchronous active-low aresetn clears the pipeline, the trigger state
// and loads the register defaults; there is no clearing pass.
// ============================================================================
module keypad_scan_trigger_control_top
    import ksc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic [3:0]            s_single_key_levels,
    input  logic [19:0]           s_matrix_levels,
    input  logic                  s_scan_allowed,
    input  logic [31:0]           s_now_time,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [MAP_W-1:0]      m_key_status,
    output logic                  m_trigger_on,
    output logic [1:0]            m_auto_mode
);

    // The block is a two-register pipeline. Each accepted word is captured in
    // the input register; the step logic evaluates it against the controller
    // state, which is updated in the same edge that loads the result register.
    // The result register and the input register are separate, so a new word
    // can be taken while a finished result still waits on m_ready.

    cfg_t       cfg_reg;
    ctl_state_t state_reg;
    ctl_state_t state_next;

    logic        in_valid_reg;
    logic        in_action_reg;
    logic [3:0]  in_single_reg;
    logic [19:0] in_matrix_reg;
    logic        in_allowed_reg;
    logic [31:0] in_now_reg;

    logic             out_valid_reg;
    logic [MAP_W-1:0] out_status_reg;
    logic             out_trigger_reg;
    logic [1:0]       out_mode_reg;

    logic [MAP_W-1:0] status_next;
    logic             advance;

    // A word moves into the result register when the result slot is free or
    // is being emptied in this same cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_valid      = out_valid_reg;
    assign m_key_status = out_status_reg;
    assign m_trigger_on = out_trigger_reg;
    assign m_auto_mode  = out_mode_reg;

    // Configuration registers. Writes to an index beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.single_pol   <= RST_SINGLE_POL;
            cfg_reg.matrix_level <= RST_MATRIX_LEVEL;
            cfg_reg.hold_clear   <= RST_HOLD_CLEAR;
            cfg_reg.manual_pulse <= RST_MANUAL_PULSE;
            cfg_reg.auto_off     <= RST_AUTO_OFF;
            cfg_reg.auto_timeout <= RST_AUTO_TIMEOUT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SINGLE_POL:   cfg_reg.single_pol   <= cfg_data[3:0];
                CFG_MATRIX_LEVEL: cfg_reg.matrix_level <= cfg_data[0];
                CFG_HOLD_CLEAR:   cfg_reg.hold_clear   <= cfg_data[0];
                CFG_MANUAL_PULSE: cfg_reg.manual_pulse <= cfg_data[9:0];
                CFG_AUTO_OFF:     cfg_reg.auto_off     <= cfg_data[9:0];
                CFG_AUTO_TIMEOUT: cfg_reg.auto_timeout <= cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: payload needs no reset, only its valid flag does.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg  <= s_action;
            in_single_reg  <= s_single_key_levels;
            in_matrix_reg  <= s_matrix_levels;
            in_allowed_reg <= s_scan_allowed;
            in_now_reg     <= s_now_time;
        end
    end

    ksc_step u_step (
        .cfg               (cfg_reg),
        .cur               (state_reg),
        .action            (in_action_reg),
        .single_key_levels (in_single_reg),
        .matrix_levels     (in_matrix_reg),
        .scan_allowed      (in_allowed_reg),
        .now_time          (in_now_reg),
        .nxt               (state_next),
        .key_status        (status_next)
    );

    // Controller state and the result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.auto_state <= AUTO_OFF;
            state_reg.aim_active <= 1'b0;
            state_reg.countdown  <= '0;
            state_reg.last_read  <= '0;
            state_reg.trigger    <= 1'b0;
            out_valid_reg        <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, loaded together with the state update.
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_status_reg  <= status_next;
            out_trigger_reg <= state_next.trigger;
            out_mode_reg    <= state_next.auto_state;
        end
    end

endmodule

@@ tb/keypad_scan_trigger_control_monitor.sv @@
// ============================================================================
// keypad_scan_trigger_control_monitor
// Watches the configuration, input and result channels of the keypad scan
// and trigger block. It keeps its own model of the trigger controller,
// predicts one result word per accepted input word and compares the results
// in order. It reports the number of failures and of results still awaited.
// ============================================================================
module keypad_scan_trigger_control_monitor
    import ksc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_action,
    input  logic [3:0]            s_single_key_levels,
    input  logic [19:0]           s_matrix_levels,
    input  logic                  s_scan_allowed,
    input  logic [31:0]           s_now_time,

    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [MAP_W-1:0]      m_key_status,
    input  logic                  m_trigger_on,
    input  logic [1:0]            m_auto_mode,

    output int                    mismatches,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [MAP_W-1:0] key_map;
        logic             trigger;
        logic [1:0]       mode;
    } key_report_t;

    // Countdown value left by a clear when the trigger is held until cleared.
    localparam logic signed [10:0] COUNT_SPENT = -11'sd1;

    cfg_t               regs;
    auto_mode_t         mode_q;
    logic               aim_q;
    logic               trig_q;
    logic signed [10:0] count_q;
    logic [31:0]        last_read_q;
    key_report_t        pending_reports[$];
    int                 fail_total;

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SINGLE_POL:   regs.single_pol   = data[3:0];
            CFG_MATRIX_LEVEL: regs.matrix_level = data[0];
            CFG_HOLD_CLEAR:   regs.hold_clear   = data[0];
            CFG_MANUAL_PULSE: regs.manual_pulse = data[9:0];
            CFG_AUTO_OFF:     regs.auto_off     = data[9:0];
            CFG_AUTO_TIMEOUT: regs.auto_timeout = data[30:0];
            default: ;
        endcase
    endtask

    // A successful read: in auto mode it restarts the off period and the idle
    // timer, otherwise it only ends a held manual trigger.
    task automatic note_read(input logic [31:0] now);
        if (mode_q == AUTO_RUN) begin
            trig_q      = 1'b0;
            count_q     = $signed({1'b0, regs.auto_off});
            last_read_q = now;
        end else if (regs.hold_clear) begin
            trig_q  = 1'b0;
            count_q = COUNT_SPENT;
        end
    endtask

    task automatic advance_trigger(input logic key);
        logic signed [10:0] off;
        off = $signed({1'b0, regs.auto_off});
        case (mode_q)
            AUTO_OFF: begin
                if (!aim_q && key) begin
                    trig_q  = 1'b1;
                    count_q = (count_q == 0) ? $signed({1'b0, regs.manual_pulse})
                                             : count_q - 11'sd1;
                    aim_q   = 1'b1;
                end else if (aim_q && !key &&
                             (!regs.hold_clear || count_q == COUNT_SPENT)) begin
                    trig_q  = 1'b0;
                    aim_q   = 1'b0;
                    count_q = '0;
                end else begin
                    if (count_q > 11'sd0)
                        count_q = count_q - 11'sd1;
                    if (aim_q && count_q == 0) begin
                        trig_q = 1'b0;
                        aim_q  = 1'b0;
                    end
                end
            end
            AUTO_ENTER: begin
                if (!key)
                    mode_q = AUTO_RUN;
            end
            AUTO_LEAVE: begin
                if (!key) begin
                    mode_q  = AUTO_OFF;
                    trig_q  = 1'b0;
                    aim_q   = 1'b0;
                    count_q = '0;
                end
            end
            default: begin
                if (count_q == 0) begin
                    count_q = $signed({1'b0, regs.manual_pulse});
                    aim_q   = 1'b0;
                end else begin
                    if (count_q > 11'sd0)
                        count_q = count_q - 11'sd1;
                    if (!aim_q && count_q >= off) begin
                        trig_q = 1'b1;
                        aim_q  = 1'b1;
                    end else if (aim_q && count_q < off) begin
                        trig_q = 1'b0;
                        aim_q  = 1'b0;
                    end
                end
            end
        endcase
    endtask

    task automatic next_key_report(input  logic                   is_clear,
                                   input  logic [3:0]             single_lv,
                                   input  logic [MATRIX_KEYS-1:0] matrix_lv,
                                   input  logic                   scan_ok,
                                   input  logic [31:0]            now,
                                   output key_report_t            rep);
        logic [MAP_W-1:0] map;
        logic             entering;
        map = '0;
        if (is_clear) begin
            note_read(now);
        end else begin
            map[SINGLE_KEYS-1:0]     = ~(single_lv ^ regs.single_pol);
            map[MAP_W-1:SINGLE_KEYS] = regs.matrix_level ? matrix_lv : ~matrix_lv;
            if (map[COMBO_A_BIT] && map[COMBO_B_BIT]) begin
                if (mode_q == AUTO_OFF) begin
                    aim_q   = 1'b0;
                    mode_q  = AUTO_ENTER;
                    count_q = '0;
                    trig_q  = 1'b1;
                end else if (mode_q == AUTO_RUN) begin
                    mode_q = AUTO_LEAVE;
                end
                map[COMBO_B_BIT] = 1'b0;
            end
            if (mode_q == AUTO_RUN && (now - last_read_q) >= {1'b0, regs.auto_timeout})
                mode_q = AUTO_LEAVE;
            if (scan_ok) begin
                entering = (mode_q == AUTO_ENTER);
                advance_trigger(|map[SCAN_KEY_HI:SCAN_KEY_LO]);
                if (entering && mode_q == AUTO_RUN)
                    last_read_q = now;
            end
        end
        rep.key_map = map;
        rep.trigger = trig_q;
        rep.mode    = mode_q;
    endtask

    always @(posedge aclk) begin
        key_report_t want;
        if (!aresetn) begin
            regs.single_pol   = RST_SINGLE_POL;
            regs.matrix_level = RST_MATRIX_LEVEL;
            regs.hold_clear   = RST_HOLD_CLEAR;
            regs.manual_pulse = RST_MANUAL_PULSE;
            regs.auto_off     = RST_AUTO_OFF;
            regs.auto_timeout = RST_AUTO_TIMEOUT;
            mode_q      = AUTO_OFF;
            aim_q       = 1'b0;
            trig_q      = 1'b0;
            count_q     = '0;
            last_read_q = '0;
            pending_reports.delete();
            fail_total  = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_data);

            // Results are checked before the new prediction is queued, so a
            // result can never be matched against the word accepted with it.
            if (m_valid && m_ready) begin
                if (pending_reports.size() == 0) begin
                    $error("unexpected result word: key_status %h trigger_on %b auto_mode %0d",
                           m_key_status, m_trigger_on, m_auto_mode);
                    fail_total++;
                end else begin
                    want = pending_reports.pop_front();
                    if (want.key_map !== m_key_status) begin
                        $error("key_status: expected %h, got %h", want.key_map, m_key_status);
                        fail_total++;
                    end
                    if (want.trigger !== m_trigger_on) begin
                        $error("trigger_on: expected %b, got %b", want.trigger, m_trigger_on);
                        fail_total++;
                    end
                    if (want.mode !== m_auto_mode) begin
                        $error("auto_mode: expected %0d, got %0d", want.mode, m_auto_mode);
                        fail_total++;
                    end
                end
            end

            if (s_valid && s_ready) begin
                next_key_report(s_action, s_single_key_levels, s_matrix_levels,
                                s_scan_allowed, s_now_time, want);
                pending_reports.push_back(want);
            end
        end
        mismatches  <= fail_total;
        outstanding <= pending_reports.size();
    end

endmodule

@@ tb/keypad_scan_trigger_control_top_tb.sv @@
// ============================================================================
// keypad_scan_trigger_control_top_tb
// Drives the keypad scan and trigger block with a short directed opening and
// then segments of randomised key sessions under several register settings
// and handshake idling patterns. Checking is done by the monitor beside the
// block; this module makes the stimulus and gives the verdict.
// ============================================================================
module keypad_scan_trigger_control_top_tb;
    import ksc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Input word actions.
    localparam logic ACT_SCAN  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // Key map groups used to build sessions: the mode combination and the
    // keys that fire the scanner.
    localparam logic [MAP_W-1:0] COMBO_KEYS =
        (MAP_W'(1) << COMBO_A_BIT) | (MAP_W'(1) << COMBO_B_BIT);
    localparam logic [MAP_W-1:0] SCAN_KEYS_MAP =
        ((MAP_W'(1) << (SCAN_KEY_HI + 1)) - MAP_W'(1)) ^
        ((MAP_W'(1) << SCAN_KEY_LO) - MAP_W'(1));

    localparam int SEGMENTS       = 8;
    localparam int SEGMENT_WORDS  = 228;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_action;
    logic [3:0]            s_single_key_levels;
    logic [19:0]           s_matrix_levels;
    logic                  s_scan_allowed;
    logic [31:0]           s_now_time;
    logic                  m_valid;
    logic                  m_ready;
    logic [MAP_W-1:0]      m_key_status;
    logic                  m_trigger_on;
    logic [1:0]            m_auto_mode;
    int                    mismatches;
    int                    outstanding;

    // Stimulus-side copy of the register settings, used only to turn a
    // wanted set of pressed keys into raw levels and to size sessions.
    logic [3:0]  key_polarity = RST_SINGLE_POL;
    logic        col_level    = RST_MATRIX_LEVEL;
    int          pulse_len    = RST_MANUAL_PULSE;
    logic [30:0] idle_timeout = RST_AUTO_TIMEOUT;

    logic [31:0] clock_ticks;
    int          words_sent;
    int          sender_idle_pct;
    int          receiver_stall_pct;
    bit          hold_req;
    int          quiet_cycles;

    keypad_scan_trigger_control_top dut (.*);

    keypad_scan_trigger_control_monitor u_monitor (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog: a correct run never goes this long without some word moving
    // on one of the three channels, even through the long receiver hold-off.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Result side. Ready is redrawn every cycle against the stall rate of the
    // current phase. When a hold-off is requested, ready stays low for a long
    // stretch counted here, so that the block fills and back-pressures its
    // input while the sender keeps offering words.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    // Offers one input word and returns at the edge where it is taken. Idle
    // cycles are drawn before the word, so valid never drops once raised.
    task automatic send_word(input logic action, input logic [3:0] single_lv,
                             input logic [19:0] matrix_lv, input logic scan_ok,
                             input logic [31:0] now);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_action            <= action;
        s_single_key_levels <= single_lv;
        s_matrix_levels     <= matrix_lv;
        s_scan_allowed      <= scan_ok;
        s_now_time          <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    // One scan tick with the given keys held down. Time usually moves on by
    // one tick, now and then by none or a few.
    task automatic scan(input logic [MAP_W-1:0] pressed, input logic scan_ok);
        logic [3:0]             single_lv;
        logic [MATRIX_KEYS-1:0] matrix_lv;
        clock_ticks = clock_ticks + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 1);
        single_lv   = ~(pressed[SINGLE_KEYS-1:0] ^ key_polarity);
        matrix_lv   = col_level ? pressed[MAP_W-1:SINGLE_KEYS]
                                : ~pressed[MAP_W-1:SINGLE_KEYS];
        send_word(ACT_SCAN, single_lv, matrix_lv, scan_ok, clock_ticks);
    endtask

    // A successful barcode read; the key levels carried with it are ignored
    // by the block, so they are random.
    task automatic read_done();
        send_word(ACT_CLEAR, 4'($urandom), 20'($urandom), 1'($urandom), clock_ticks);
    endtask

    // Sparse background keys that neither fire the scanner nor form the
    // mode combination.
    function automatic logic [MAP_W-1:0] stray_keys();
        return MAP_W'($urandom & $urandom & $urandom) & ~(SCAN_KEYS_MAP | COMBO_KEYS);
    endfunction

    function automatic logic [MAP_W-1:0] scan_pick();
        return MAP_W'($urandom_range(1, (1 << (SCAN_KEY_HI - SCAN_KEY_LO + 1)) - 1))
               << SCAN_KEY_LO;
    endfunction

    // The sender stops and waits until every predicted result has come back,
    // then gives the two-register pipeline a little slack before going on.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Register write; the bits above a register's width carry random junk,
    // which the block must ignore.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value, input int width);
        logic [CFG_DATA_W-1:0] keep;
        keep = (width >= CFG_DATA_W) ? '1 : CFG_DATA_W'((64'd1 << width) - 1);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (value & keep) | (CFG_DATA_W'($urandom) & ~keep);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // All six registers are rewritten with the block drained and idle.
    task automatic program_regs(input logic [3:0] pol, input logic level,
                                input logic hold, input int pulse, input int off,
                                input logic [30:0] timeout);
        wait_idle();
        write_reg(CFG_SINGLE_POL,   CFG_DATA_W'(pol),     4);
        write_reg(CFG_MATRIX_LEVEL, CFG_DATA_W'(level),   1);
        write_reg(CFG_HOLD_CLEAR,   CFG_DATA_W'(hold),    1);
        write_reg(CFG_MANUAL_PULSE, CFG_DATA_W'(pulse),   10);
        write_reg(CFG_AUTO_OFF,     CFG_DATA_W'(off),     10);
        write_reg(CFG_AUTO_TIMEOUT, CFG_DATA_W'(timeout), 31);
        cfg_valid    <= 1'b0;
        key_polarity = pol;
        col_level    = level;
        pulse_len    = pulse;
        idle_timeout = timeout;
    endtask

    // A manual scan: some scan keys held for about the pulse length, then
    // released, sometimes followed by a successful read.
    task automatic manual_press();
        logic [MAP_W-1:0] held;
        int               span;
        held = stray_keys() | scan_pick();
        span = $urandom_range(1, (pulse_len > 30) ? 30 : pulse_len + 3);
        repeat (span) scan(held, $urandom_range(0, 9) != 0);
        repeat ($urandom_range(1, 4)) scan(stray_keys(), 1'b1);
        if ($urandom_range(0, 2) == 0) begin
            read_done();
            scan(stray_keys(), 1'b1);
        end
    endtask

    // An auto-scan session: the combination switches auto mode on, the
    // trigger then pulses with the odd read, stray scan key or blocked screen
    // mixed in, and the session ends by the combination or by the idle timeout.
    task automatic auto_session();
        logic [MAP_W-1:0] idle_map;
        int               ticks;
        idle_map = stray_keys();
        repeat ($urandom_range(1, 3)) scan(COMBO_KEYS | stray_keys(), 1'b1);
        scan(idle_map, 1'b1);
        ticks = $urandom_range(1, 40);
        repeat (ticks) begin
            case ($urandom_range(0, 19))
                0:       read_done();
                1:       scan(idle_map | scan_pick(), 1'b1);
                2:       scan(idle_map, 1'b0);
                default: scan(idle_map, 1'b1);
            endcase
        end
        if ($urandom_range(0, 1) == 0)
            repeat ($urandom_range(1, 2)) scan(COMBO_KEYS, 1'b1);
        else
            clock_ticks = clock_ticks + idle_timeout;
        scan(idle_map, 1'b1);
    endtask

    // Unstructured words: any action, any levels, any time stamp.
    task automatic noise_burst();
        repeat ($urandom_range(1, 6))
            send_word(1'($urandom), 4'($urandom), 20'($urandom), 1'($urandom),
                      ($urandom_range(0, 1) == 0) ? $urandom : clock_ticks);
    endtask

    initial begin
        int seg;
        int target;

        aresetn             = 1'b0;
        cfg_valid           = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        s_valid             = 1'b0;
        s_action            = ACT_SCAN;
        s_single_key_levels = '0;
        s_matrix_levels     = '0;
        s_scan_allowed      = 1'b0;
        s_now_time          = '0;
        clock_ticks         = '0;
        words_sent          = 0;
        sender_idle_pct     = 0;
        receiver_stall_pct  = 0;
        hold_req            = 1'b0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening with the reset settings. All levels low presses
        // every matrix key and the combination, so auto mode starts at once;
        // all levels high then releases it at the top of the time range.
        send_word(ACT_SCAN, 4'h0, 20'h00000, 1'b1, 32'h0000_0000);
        send_word(ACT_SCAN, 4'hF, 20'hFFFFF, 1'b1, 32'hFFFF_FFFF);
        // A read in auto mode, at a time that has wrapped past zero.
        send_word(ACT_CLEAR, 4'hA, 20'h5A5A5, 1'b0, 32'h0000_0000);
        // Screen blocked, and half the time range elapsed: only the timeout
        // is handled, which sends auto mode towards off.
        send_word(ACT_SCAN, 4'h5, 20'hA5A5A, 1'b0, 32'h8000_0000);

        // Inverted polarities, hold-until-clear and short counts.
        program_regs(4'hF, 1'b1, 1'b1, 3, 1, 31'd20);
        clock_ticks = 32'h0000_1000;
        scan(MAP_W'(1) << SCAN_KEY_LO, 1'b1);
        scan(MAP_W'(1) << SCAN_KEY_LO, 1'b1);
        scan('0, 1'b1);
        read_done();
        scan('0, 1'b1);
        scan(MAP_W'(1) << SCAN_KEY_HI, 1'b0);
        scan(COMBO_KEYS, 1'b1);
        scan('0, 1'b1);
        repeat (3) scan('0, 1'b1);
        read_done();
        clock_ticks = clock_ticks + 1000;
        scan('0, 1'b1);
        scan(COMBO_KEYS, 1'b1);
        scan('0, 1'b1);
        scan(COMBO_KEYS, 1'b1);
        scan('0, 1'b1);
        send_word(ACT_SCAN, 4'($urandom), 20'($urandom), 1'b1, $urandom);

        // Random segments. Each segment starts from a drained block with new
        // register values: the first two take the low and high extremes, the
        // rest short counts so that pulses and timeouts happen often.
        for (seg = 0; seg < SEGMENTS; seg++) begin
            case (seg % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
                default: begin sender_idle_pct = 27; receiver_stall_pct = 27; end
            endcase

            if (seg == 0)
                program_regs(4'h0, 1'b0, 1'b0, 1, 0, 31'd1);
            else if (seg == 1)
                program_regs(4'hF, 1'b1, 1'b1, 1023, 1023, 31'h7FFF_FFFF);
            else
                program_regs(4'($urandom), 1'($urandom), 1'($urandom),
                             $urandom_range(1, 24), $urandom_range(0, 12),
                             31'($urandom_range(4, 120)));

            // With the sender running flat out, the receiver holds off for a
            // long stretch so that the block fills up and stalls its input.
            if (seg == 4)
                hold_req = 1'b1;

            // Run the tick counter across its wrap point.
            if (seg == 5)
                clock_ticks = 32'hFFFF_FF80;

            target = words_sent + SEGMENT_WORDS;
            while (words_sent < target) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: manual_press();
                    5, 6, 7:       auto_session();
                    default:       noise_burst();
                endcase
            end
        end

        wait_idle();
        @(negedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
sv/ksc_pkg.sv
sv/ksc_step.sv
sv/keypad_scan_trigger_control_top.sv
tb/keypad_scan_trigger_control_monitor.sv
tb/keypad_scan_trigger_control_top_tb.sv
